// File: rtl/lud_pkg.sv
package lud_pkg;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic       load_wr;   // write the incoming word into the upper store
        logic       rd;        // read both stores at the given address
        logic       piv_cap;   // take the read word as the pivot
        logic       div_start; // start the multiplier division
        logic       l_cap;     // take the divider quotient as the multiplier
        logic       l_zero;    // zero pivot: multiplier is zero, mark singular
        logic       mul;       // product of multiplier and read word
        logic       upd_wr;    // write the updated upper entry
        logic       low_wr;    // write the multiplier into the lower store
        logic       flag_clr;  // clear both flags at the start of a run
        logic       out_cap;   // load the output register
        logic [1:0] row;
        logic [1:0] col;
        logic       diag;
        logic       below;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic piv_zero;
        logic div_done;
    } t_status;

    localparam logic [2:0] SIZE_RESET = 3'd4;
    localparam int unsigned MIN_SIZE = 2;

endpackage

// File: rtl/lud_div.sv
module lud_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot,
    output logic               o_ovf
);
    localparam int DW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [33:0]     r_rem;
    logic [DW-1:0]   r_sh;
    logic [32:0]     r_dmag;
    logic            r_neg;

    logic [32:0] num_ext;
    logic [32:0] den_ext;
    logic [32:0] num_mag;
    logic [32:0] den_mag;
    logic [33:0] trial;
    logic        fits;
    logic        hi;

    assign num_ext = {i_num[31], i_num};
    assign den_ext = {i_den[31], i_den};
    assign num_mag = i_num[31] ? (33'd0 - num_ext) : num_ext;
    assign den_mag = i_den[31] ? (33'd0 - den_ext) : den_ext;
    assign trial   = {r_rem[32:0], r_sh[DW-1]};
    assign fits    = trial >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle shifted in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_sh   <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
            r_dmag <= den_mag;
            r_neg  <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dmag}) : trial;
            r_sh  <= {r_sh[DW-2:0], fits};
        end
    end

    assign hi     = |r_sh[DW-1:32];
    assign o_done = r_done;

    always_comb begin
        if (r_neg) begin
            o_ovf  = hi | (r_sh[31] & (|r_sh[30:0]));
            o_quot = o_ovf ? 32'sh8000_0000 : $signed(32'd0 - r_sh[31:0]);
        end else begin
            o_ovf  = hi | r_sh[31];
            o_quot = o_ovf ? 32'sh7fff_ffff : $signed(r_sh[31:0]);
        end
    end

endmodule

// File: rtl/lud_dp.sv
module lud_dp #(
    parameter int MAX_N     = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lud_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(MAX_N*MAX_N)-1:0]      i_addr,
    input  logic signed [31:0]                  i_element_value,
    output lud_pkg::t_status                    o_status,
    output logic [1:0]                          o_row_index,
    output logic [1:0]                          o_col_index,
    output logic signed [31:0]                  o_lower_value,
    output logic signed [31:0]                  o_upper_value,
    output logic                                o_singular_flag,
    output logic                                o_overflow_flag,
    output logic                                o_last_result
);
    import lud_pkg::*;

    localparam int DEPTH = MAX_N * MAX_N;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] r_umem [DEPTH];
    logic signed [31:0] r_lmem [DEPTH];

    logic signed [31:0] r_rd_u;
    logic signed [31:0] r_rd_l;
    logic signed [31:0] r_piv;
    logic signed [31:0] r_l;
    logic signed [63:0] r_prod;
    logic               r_sing;
    logic               r_ovf;

    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_up;
    logic               r_sing_o;
    logic               r_ovf_o;
    logic               r_last;

    logic               div_done;
    logic signed [31:0] div_quot;
    logic               div_ovf;

    logic signed [63:0] prod_fl;
    logic signed [64:0] diff;
    logic               upd_ovf;
    logic signed [31:0] upd_val;

    lud_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_rd_u),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // arithmetic shift floors toward minus infinity
    assign prod_fl = r_prod >>> FRAC_BITS;
    assign diff    = {r_rd_u[31], {33{r_rd_u[31]}}, r_rd_u[30:0]} - {prod_fl[63], prod_fl};
    assign upd_ovf = !((&diff[64:31]) || !(|diff[64:31]));
    assign upd_val = upd_ovf ? (diff[64] ? 32'sh8000_0000 : 32'sh7fff_ffff) : diff[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_umem[i_addr] <= i_element_value;
        end else if (i_cmd.upd_wr) begin
            r_umem[i_addr] <= upd_val;
        end
        if (i_cmd.low_wr) begin
            r_lmem[i_addr] <= r_l;
        end
        if (i_cmd.rd) begin
            r_rd_u <= r_umem[i_addr];
            r_rd_l <= r_lmem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.piv_cap) begin
            r_piv <= r_rd_u;
        end
        if (i_cmd.l_cap) begin
            r_l <= div_quot;
        end else if (i_cmd.l_zero) begin
            r_l <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= r_l * r_rd_u;
        end
        if (i_cmd.out_cap) begin
            r_row    <= i_cmd.row;
            r_col    <= i_cmd.col;
            r_lo     <= i_cmd.diag ? ONE : (i_cmd.below ? r_rd_l : 32'sd0);
            r_up     <= i_cmd.below ? 32'sd0 : r_rd_u;
            r_sing_o <= r_sing;
            r_ovf_o  <= r_ovf;
            r_last   <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sing <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.flag_clr) begin
            r_sing <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.l_zero) begin
                r_sing <= 1'b1;
            end
            if ((i_cmd.l_cap && div_ovf) || (i_cmd.upd_wr && upd_ovf)) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_status.piv_zero = (r_piv == 32'sd0);
    assign o_status.div_done = div_done;

    assign o_row_index     = r_row;
    assign o_col_index     = r_col;
    assign o_lower_value   = r_lo;
    assign o_upper_value   = r_up;
    assign o_singular_flag = r_sing_o;
    assign o_overflow_flag = r_ovf_o;
    assign o_last_result   = r_last;

endmodule

// File: rtl/lud_ctrl.sv
module lud_ctrl #(
    parameter int MAX_N = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [2:0]                     i_matrix_size,
    output logic                           o_cfg_ready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  lud_pkg::t_status               i_status,
    output lud_pkg::t_cmd                  o_cmd,
    output logic [$clog2(MAX_N*MAX_N)-1:0] o_addr
);
    import lud_pkg::*;

    localparam int AW = $clog2(MAX_N * MAX_N);
    localparam int CW = $clog2(MAX_N + 1);
    localparam int PW = 2 * CW;
    localparam int LW = $clog2(MAX_N * MAX_N + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_RPIV, S_CPIV, S_RIK, S_DIV, S_DIVW, S_LWR,
        S_RKJ, S_RIJ, S_UPD, S_ORD, S_OCAP, S_OWAIT
    } t_state;

    t_state        r_state;
    logic [2:0]    r_size;
    logic [LW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_k;
    logic          r_out_valid;

    logic [CW-1:0] n_act;
    logic [CW-1:0] n_last;
    logic [LW-1:0] nn;
    logic          in_acc;
    logic          pos_last;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                              input logic [CW-1:0] n);
        logic [PW-1:0] p;
        p = PW'(r) * PW'(n) + PW'(c);
        return p[AW-1:0];
    endfunction

    always_comb begin
        if ({1'b0, r_size} < 4'(MIN_SIZE)) begin
            n_act = CW'(MIN_SIZE);
        end else if ({1'b0, r_size} > 4'(MAX_N)) begin
            n_act = CW'(MAX_N);
        end else begin
            n_act = CW'(r_size);
        end
    end

    assign n_last   = n_act - 1'b1;
    assign nn       = LW'(PW'(n_act) * PW'(n_act));
    assign in_acc   = i_in_valid && (r_state == S_LOAD);
    assign pos_last = (r_i == n_last) && (r_j == n_last);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_addr      = '0;
        o_cmd.row   = 2'(r_i);
        o_cmd.col   = 2'(r_j);
        o_cmd.diag  = (r_i == r_j);
        o_cmd.below = (r_i > r_j);
        o_cmd.last  = pos_last;
        case (r_state)
            S_LOAD: begin
                o_addr        = AW'(r_cnt);
                o_cmd.load_wr = in_acc;
                o_cmd.flag_clr = in_acc && (r_cnt + 1'b1 >= nn);
            end
            S_RPIV: begin
                o_addr   = addr_of(r_k, r_k, n_act);
                o_cmd.rd = 1'b1;
            end
            S_CPIV: o_cmd.piv_cap = 1'b1;
            S_RIK: begin
                o_addr   = addr_of(r_i, r_k, n_act);
                o_cmd.rd = 1'b1;
            end
            S_DIV: begin
                o_cmd.l_zero    = i_status.piv_zero;
                o_cmd.div_start = !i_status.piv_zero;
            end
            S_DIVW: o_cmd.l_cap = i_status.div_done;
            S_LWR: begin
                o_addr       = addr_of(r_i, r_k, n_act);
                o_cmd.low_wr = 1'b1;
            end
            S_RKJ: begin
                o_addr   = addr_of(r_k, r_j, n_act);
                o_cmd.rd = 1'b1;
            end
            S_RIJ: begin
                o_addr    = addr_of(r_i, r_j, n_act);
                o_cmd.rd  = 1'b1;
                o_cmd.mul = 1'b1;
            end
            S_UPD: begin
                o_addr       = addr_of(r_i, r_j, n_act);
                o_cmd.upd_wr = 1'b1;
            end
            S_ORD: begin
                o_addr   = addr_of(r_i, r_j, n_act);
                o_cmd.rd = 1'b1;
            end
            S_OCAP: o_cmd.out_cap = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_size      <= SIZE_RESET;
            r_cnt       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_matrix_size;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_cnt + 1'b1 >= nn) begin
                            r_cnt   <= '0;
                            r_k     <= '0;
                            r_state <= S_RPIV;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_RPIV: r_state <= S_CPIV;
                S_CPIV: begin
                    r_i     <= r_k + 1'b1;
                    r_state <= S_RIK;
                end
                S_RIK: r_state <= S_DIV;
                S_DIV: r_state <= i_status.piv_zero ? S_LWR : S_DIVW;
                S_DIVW: begin
                    if (i_status.div_done) begin
                        r_state <= S_LWR;
                    end
                end
                S_LWR: begin
                    r_j     <= r_k + 1'b1;
                    r_state <= S_RKJ;
                end
                S_RKJ: r_state <= S_RIJ;
                S_RIJ: r_state <= S_UPD;
                S_UPD: begin
                    if (r_j != n_last) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RKJ;
                    end else if (r_i != n_last) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RIK;
                    end else if (r_k + 1'b1 != n_last) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RPIV;
                    end else begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_ORD;
                    end
                end
                S_ORD: r_state <= S_OCAP;
                S_OCAP: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (pos_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            if (r_j == n_last) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_status.piv_zero)
        else $error("division started on a zero pivot");

    a_upd_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd_wr |-> (r_i > r_k) && (r_j > r_k))
        else $error("update outside the trailing submatrix");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_i) && $stable(r_j))
        else $error("stalled result position moved");

    a_no_load_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input open while results pending");

endmodule

// File: rtl/lu_decomposition_no_pivot_core.sv
// LU decomposition without pivoting (Doolittle), signed fixed point (Q16.16 at the default FRAC_BITS).
// Input channel: i_in_valid / o_in_stall carries one word per matrix element,
// row-major. After n*n words (n from the size register, clamped to 2..MAX_N)
// elimination runs, with the input stalled, then n*n result words leave on
// o_out_valid / i_out_stall in row-major order, each with its L and U entry.
// Configuration: i_cfg_valid / o_cfg_ready writes the matrix size; ready is
// always high. Write it only while the block is idle.
// Elimination: per pivot the diagonal entry is read and captured; per row
// below it the multiplier comes from the serial divider (zero on a zero
// pivot, which marks the matrix singular) and is written to the L store,
// then each entry of that row right of the pivot is read, multiplied and
// updated. Each result word is read out only after the last one was taken.
// Reset clears the load count, the flags and the output valid, and sets the
// size to 4. When the receiver stalls, the current result word holds and the
// sequence waits.
module lu_decomposition_no_pivot_core #(
    parameter int MAX_N     = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_matrix_size,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_element_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_row_index,
    output logic [1:0]         o_col_index,
    output logic signed [31:0] o_lower_value,
    output logic signed [31:0] o_upper_value,
    output logic               o_singular_flag,
    output logic               o_overflow_flag,
    output logic               o_last_result
);
    import lud_pkg::*;

    localparam int AW = $clog2(MAX_N * MAX_N);

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] addr;

    lud_ctrl #(.MAX_N(MAX_N)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_matrix_size (i_matrix_size),
        .o_cfg_ready   (o_cfg_ready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_addr        (addr)
    );

    lud_dp #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .i_element_value (i_element_value),
        .o_status        (status),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_lower_value   (o_lower_value),
        .o_upper_value   (o_upper_value),
        .o_singular_flag (o_singular_flag),
        .o_overflow_flag (o_overflow_flag),
        .o_last_result   (o_last_result)
    );

endmodule
